// ===== rtl/mm3_pkg.sv =====
// Package for the streaming MurmurHash3 (x86, 32-bit) hash unit.
// Holds the word width, the mixing constants, the sequencer state type and the rotate helpers.
// No dependencies.
package mm3_pkg;

   localparam int HashWidth = 32;
   localparam int ByteWidth = 8;

   localparam logic [HashWidth-1:0] MixC1    = 32'hcc9e2d51;
   localparam logic [HashWidth-1:0] MixC2    = 32'h1b873593;
   localparam logic [HashWidth-1:0] MixN     = 32'he6546b64;
   localparam logic [HashWidth-1:0] FinM1    = 32'h85ebca6b;
   localparam logic [HashWidth-1:0] FinM2    = 32'hc2b2ae35;
   localparam logic [HashWidth-1:0] SeedInit = 32'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K_C1,
      ST_K_C2,
      ST_K_MIX,
      ST_FIN_SEL,
      ST_T_C1,
      ST_T_C2,
      ST_T_XOR,
      ST_FIN_LEN,
      ST_FIN_M2,
      ST_FIN_OUT
   } mm3_state_type;

   function automatic logic [HashWidth-1:0] rotl15(input logic [HashWidth-1:0] x);
      return {x[HashWidth-16:0], x[HashWidth-1:HashWidth-15]};
   endfunction

   function automatic logic [HashWidth-1:0] rotl13(input logic [HashWidth-1:0] x);
      return {x[HashWidth-14:0], x[HashWidth-1:HashWidth-13]};
   endfunction

endpackage

// ===== rtl/mm3_mul.sv =====
// Shared 32 x 32 multiplier with a registered low-half product.
// Used by the hash sequencer for the multiplications by the mixing and finaliser constants.
// Depends on mm3_pkg.
module mm3_mul (
   input  logic                           clock,
   input  logic [mm3_pkg::HashWidth-1:0]  op_a,
   input  logic [mm3_pkg::HashWidth-1:0]  op_b,
   output logic [mm3_pkg::HashWidth-1:0]  product
);
   import mm3_pkg::*;

   logic [HashWidth-1:0] product_ff;
   logic [HashWidth-1:0] product_in;

   // keep the low word of the product
   assign product_in = op_a * op_b;

   // register the product for the next step
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/murmur3_32bit_stream_hash_unit.sv =====
// Top level of the streaming MurmurHash3 (x86, 32-bit) hash unit.
// Holds the key state, the step sequencer and the result register.
// Depends on mm3_pkg and mm3_mul.
//
// Usage:
//   Key bytes arrive on the req_ channel, one request each. req_tuser high marks
//   req_tdata as a key byte; req_tlast ends the key and asks for its hash. A
//   request with req_tuser low and req_tlast high hashes the bytes so far (or the
//   empty key); one with both low is ignored.
//   The finished hash leaves on the rsp_ channel, one response per key.
//   csr_wr_en / csr_wr_data set the seed; between keys it also reloads the hash.
// Sequencing:
//   A byte that does not complete a 4-byte chunk leaves the sequencer idle. A byte that
//   completes a chunk starts two multiplies and the mix step. Ending a key runs the
//   tail scramble (two multiplies and an XOR) if there is a 1 to 3 byte tail, then the
//   two finaliser multiplies, then loads the response. The shared 32 x 32 multiplier,
//   one product per cycle, sets this order; req_tready is low while the sequencer works.
// Reset:
//   reset (synchronous) sets the seed to 5, clears the key state and drops rsp_tvalid.
// Stalls:
//   A response waits in its register until rsp_tready; new requests are still
//   taken, and only the next response waits for the register to empty.
module murmur3_32bit_stream_hash_unit (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [mm3_pkg::HashWidth-1:0]  csr_wr_data,   // hash_seed
   // requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mm3_pkg::ByteWidth-1:0]  req_tdata,     // [7:0] data_byte
   input  logic                           req_tuser,     // [0] has_byte
   input  logic                           req_tlast,     // last_byte
   // responses
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mm3_pkg::HashWidth-1:0]  rsp_tdata      // [31:0] hash_value
);
   import mm3_pkg::*;

   mm3_state_type        state_ff, state_in;
   logic [HashWidth-1:0] seed_ff, seed_in;
   logic [HashWidth-1:0] hash_ff, hash_in;
   logic [23:0]          partial_ff, partial_in;
   logic [1:0]           bic_ff, bic_in;
   logic [HashWidth-1:0] len_ff, len_in;
   logic [HashWidth-1:0] k_ff, k_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HashWidth-1:0] rsp_data_ff, rsp_data_in;

   logic [HashWidth-1:0] mul_a, mul_b, product;
   logic [HashWidth-1:0] mix_t, fin_t, fold_t;
   logic                 out_free;

   mm3_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state, key state and multiplier operands
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      hash_in      = hash_ff;
      partial_in   = partial_ff;
      bic_in       = bic_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      req_tready   = 1'b0;
      mix_t        = rotl13(hash_ff ^ product);
      fin_t        = hash_ff ^ len_ff;
      fold_t       = product ^ (product >> 13);

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               last_in = req_tlast;
               if (req_tuser) begin
                  len_in = len_ff + HashWidth'(1);
                  if (bic_ff == 2'd3) begin
                     k_in       = {req_tdata, partial_ff};
                     partial_in = '0;
                     bic_in     = '0;
                     state_in   = ST_K_C1;
                  end else begin
                     case (bic_ff)
                        2'd0:    partial_in[7:0]   = req_tdata;
                        2'd1:    partial_in[15:8]  = req_tdata;
                        2'd2:    partial_in[23:16] = req_tdata;
                        default: partial_in        = partial_ff;
                     endcase
                     bic_in = bic_ff + 2'd1;
                     if (req_tlast) begin
                        state_in = ST_FIN_SEL;
                     end
                  end
               end else if (req_tlast) begin
                  state_in = ST_FIN_SEL;
               end
            end
         end
         // scramble the full chunk
         ST_K_C1: begin
            mul_a    = k_ff;
            mul_b    = MixC1;
            state_in = ST_K_C2;
         end
         ST_K_C2: begin
            mul_a    = rotl15(product);
            mul_b    = MixC2;
            state_in = ST_K_MIX;
         end
         // fold the chunk into the hash: times 5 as shift and add
         ST_K_MIX: begin
            hash_in  = mix_t + {mix_t[HashWidth-3:0], 2'b00} + MixN;
            state_in = last_ff ? ST_FIN_SEL : ST_IDLE;
         end
         ST_FIN_SEL: begin
            state_in = (bic_ff != 2'd0) ? ST_T_C1 : ST_FIN_LEN;
         end
         // scramble the tail
         ST_T_C1: begin
            mul_a    = {8'd0, partial_ff};
            mul_b    = MixC1;
            state_in = ST_T_C2;
         end
         ST_T_C2: begin
            mul_a    = rotl15(product);
            mul_b    = MixC2;
            state_in = ST_T_XOR;
         end
         ST_T_XOR: begin
            hash_in  = hash_ff ^ product;
            state_in = ST_FIN_LEN;
         end
         // avalanche finaliser
         ST_FIN_LEN: begin
            mul_a    = fin_t ^ (fin_t >> 16);
            mul_b    = FinM1;
            state_in = ST_FIN_M2;
         end
         ST_FIN_M2: begin
            mul_a    = fold_t;
            mul_b    = FinM2;
            state_in = ST_FIN_OUT;
         end
         // hold until the response register is free, then restart the key
         ST_FIN_OUT: begin
            // keep the last product in the multiplier register while waiting
            mul_a = product;
            mul_b = HashWidth'(1);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = product ^ (product >> 16);
               hash_in      = seed_ff;
               partial_in   = '0;
               bic_in       = '0;
               len_in       = '0;
               last_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // seed write; between keys it reloads the hash too
      if (csr_wr_en) begin
         seed_in = csr_wr_data;
         if (len_ff == '0) begin
            hash_in = csr_wr_data;
         end
      end
   end

   // control and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SeedInit;
         hash_ff      <= SeedInit;
         partial_ff   <= '0;
         bic_ff       <= '0;
         len_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         partial_ff   <= partial_in;
         bic_ff       <= bic_in;
         len_ff       <= len_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/mm3_checker.sv =====
// Port-level checker for the streaming MurmurHash3 hash unit, bound to the top level.
// Depends on mm3_pkg and murmur3_32bit_stream_hash_unit.
module mm3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_wr_en,
   input logic [mm3_pkg::HashWidth-1:0]  csr_wr_data,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [mm3_pkg::ByteWidth-1:0]  req_tdata,
   input logic                           req_tuser,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mm3_pkg::HashWidth-1:0]  rsp_tdata
);
   import mm3_pkg::*;

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its hash
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a request that does not end a key never produces a response at once
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response without end of key");

   // ending a key busies the sequencer
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("ready right after end of key");

endmodule

bind murmur3_32bit_stream_hash_unit mm3_checker u_mm3_checker (.*);

// ===== tb/sv/murmur3_hash_checker.sv =====
// Checker for the streaming MurmurHash3 (x86, 32-bit) hash unit.
// Watches the csr_, req_ and rsp_ channels, predicts each key hash and compares responses.
// Depends on mm3_pkg for the port widths only.
`timescale 1ns / 100ps

module murmur3_hash_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mm3_pkg::HashWidth-1:0]  csr_wr_data,   // hash_seed
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [mm3_pkg::ByteWidth-1:0]  req_tdata,     // [7:0] data_byte
   input  logic                           req_tuser,     // [0] has_byte
   input  logic                           req_tlast,     // last_byte
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [mm3_pkg::HashWidth-1:0]  rsp_tdata,     // [31:0] hash_value
   output int                             fail_count,
   output int                             hashes_pending
);

   localparam logic [31:0] K_MUL1    = 32'hcc9e2d51;
   localparam logic [31:0] K_MUL2    = 32'h1b873593;
   localparam logic [31:0] H_ADD     = 32'he6546b64;
   localparam logic [31:0] AVAL_MUL1 = 32'h85ebca6b;
   localparam logic [31:0] AVAL_MUL2 = 32'hc2b2ae35;
   localparam logic [31:0] SEED_RST  = 32'd5;

   // predicted key state
   logic [31:0] seed_q;
   logic [31:0] acc_hash;
   logic [23:0] gathered;
   logic [1:0]  gathered_cnt;
   logic [31:0] key_bytes;

   logic [31:0] expected_hashes[$];

   // Scramble one little-endian word before it enters the hash
   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * K_MUL1;
      t = {t[16:0], t[31:17]};
      return t * K_MUL2;
   endfunction

   // Apply the final avalanche
   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * AVAL_MUL1;
      t = t ^ (t >> 13);
      t = t * AVAL_MUL2;
      return t ^ (t >> 16);
   endfunction

   // Fold one request into the prediction; push a hash when the key ends
   task automatic predict_request(input logic [7:0] d, input logic has, input logic lst);
      logic [31:0] h;
      if (has) begin
         key_bytes = key_bytes + 32'd1;
         if (gathered_cnt == 2'd3) begin
            acc_hash = acc_hash ^ scramble_word({d, gathered});
            acc_hash = {acc_hash[18:0], acc_hash[31:19]};
            acc_hash = acc_hash * 32'd5 + H_ADD;
            gathered = '0;
            gathered_cnt = 2'd0;
         end else begin
            gathered[8*gathered_cnt +: 8] = d;
            gathered_cnt = gathered_cnt + 2'd1;
         end
      end
      if (lst) begin
         h = acc_hash;
         if (gathered_cnt != 2'd0)
            h = h ^ scramble_word({8'h00, gathered});
         h = h ^ key_bytes;
         expected_hashes.push_back(avalanche(h));
         acc_hash = seed_q;
         gathered = '0;
         gathered_cnt = 2'd0;
         key_bytes = '0;
      end
   endtask

   // Track writes, requests and responses at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         seed_q = SEED_RST;
         acc_hash = SEED_RST;
         gathered = '0;
         gathered_cnt = 2'd0;
         key_bytes = '0;
         expected_hashes.delete();
      end else begin
         if (csr_wr_en) begin
            seed_q = csr_wr_data;
            if (key_bytes == 32'd0)
               acc_hash = seed_q;
         end
         if (req_tvalid && req_tready)
            predict_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual hash_value %08h",
                        $time, rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               if (rsp_tdata !== expected_hashes[0]) begin
                  $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                           $time, expected_hashes[0], rsp_tdata);
                  fail_count = fail_count + 1;
               end
               void'(expected_hashes.pop_front());
            end
         end
      end
      hashes_pending = expected_hashes.size();
   end

endmodule

// ===== tb/sv/murmur3_32bit_stream_hash_unit_tb.sv =====
// Testbench top for the streaming MurmurHash3 (x86, 32-bit) hash unit.
// Drives key bytes, seed writes and response back-pressure; gives the verdict.
// Depends on mm3_pkg, murmur3_32bit_stream_hash_unit and murmur3_hash_checker.
`timescale 1ns / 100ps

module murmur3_32bit_stream_hash_unit_tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 16;
   localparam int PHASE_COUNT  = 5;
   localparam int PHASE_ITEMS  = 280;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [mm3_pkg::HashWidth-1:0]  csr_wr_data;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [mm3_pkg::ByteWidth-1:0]  req_tdata;
   logic                           req_tuser;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [mm3_pkg::HashWidth-1:0]  rsp_tdata;

   int fail_count;
   int hashes_pending;
   int bytes_sent;
   int burst_left;
   int stall_mode = 0;
   int stall_tick = 0;

   logic [31:0] phase_seeds[PHASE_COUNT];

   murmur3_32bit_stream_hash_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   murmur3_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .fail_count     (fail_count),
      .hashes_pending (hashes_pending)
   );

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[murmur3_32bit_stream_hash_unit] ERROR");
      $finish;
   end

   // Stall the response side on a changing pattern
   always @(negedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 150 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= (stall_tick % 8 == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // Offer one request and hold it until accepted; open a gap between bursts
   task automatic send_request(input logic [7:0] d, input logic has, input logic lst);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= has;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      burst_left = burst_left - 1;
      if (has || lst)
         bytes_sent = bytes_sent + 1;
   endtask

   // Hold off requests until every hash has come back and the unit has settled
   task automatic drain_responses;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hashes_pending != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Write the seed while the unit is idle
   task automatic write_seed(input logic [31:0] value);
      drain_responses();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Send a key of random bytes with idle noise; optionally leave it open
   task automatic send_key(input int len, input logic end_with_byte, input logic keep_open);
      logic end_on_byte;
      end_on_byte = end_with_byte && (len > 0) && !keep_open;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!keep_open && !end_on_byte)
         send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int key_len;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      bytes_sent  = 0;
      burst_left  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed keys on the reset seed: empty key, byte with end, tails, idle step
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h5a, 1'b1, 1'b0);
      send_request(8'h3c, 1'b0, 1'b1);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'ha5, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      send_request(8'hfe, 1'b1, 1'b0);
      send_request(8'hc3, 1'b0, 1'b1);
      for (int i = 0; i < 7; i++)
         send_request(8'hff, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b1);

      phase_seeds[0] = 32'h00000000;
      phase_seeds[1] = 32'hffffffff;
      phase_seeds[2] = $urandom;
      phase_seeds[3] = 32'h80000000;
      phase_seeds[4] = $urandom;

      // Run random phases, each on its own seed; odd phases end with a key left open
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_seed(phase_seeds[p]);
         while (bytes_sent < (p + 1) * PHASE_ITEMS + 25) begin
            key_len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 80);
            send_key(key_len, 1'($urandom_range(0, 1)), 1'b0);
         end
         if (p % 2 == 1)
            send_key($urandom_range(1, 6), 1'b0, 1'b1);
      end

      // Wait for the last hashes, then settle
      drain_responses();
      if (fail_count == 0 && hashes_pending == 0)
         $display("[murmur3_32bit_stream_hash_unit] OK");
      else
         $display("[murmur3_32bit_stream_hash_unit] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mm3_pkg.sv
rtl/mm3_mul.sv
rtl/murmur3_32bit_stream_hash_unit.sv
rtl/mm3_checker.sv
tb/sv/murmur3_hash_checker.sv
tb/sv/murmur3_32bit_stream_hash_unit_tb.sv
